// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/cfpr_pkg.sv
// Types, constants and the CRC step shared by the frame receiver files.
package cfpr_pkg;

	localparam logic [7:0]  SYNC_A   = 8'hAA;
	localparam logic [7:0]  SYNC_B   = 8'h55;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	localparam int unsigned APB_DW = 32;
	localparam int unsigned APB_AW = 3;

	localparam logic [15:0] MAX_LEN_RST = 16'd136;
	localparam logic [31:0] TIMEOUT_RST = 32'd1000;

	typedef enum logic {
		REG_MAX_LEN = 1'b0,
		REG_TIMEOUT = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_CRC_BAD  = 2'd1,
		ST_LEN_LONG = 2'd2,
		ST_TIMEOUT  = 2'd3
	} status_t;

	typedef enum logic [7:0] {
		PH_HUNT1 = 8'b0000_0001,
		PH_HUNT2 = 8'b0000_0010,
		PH_CMD   = 8'b0000_0100,
		PH_LENLO = 8'b0000_1000,
		PH_LENHI = 8'b0001_0000,
		PH_DATA  = 8'b0010_0000,
		PH_CRCLO = 8'b0100_0000,
		PH_CRCHI = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic       func;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic        is_end;
		logic [7:0]  payload_byte;
		logic [7:0]  command;
		logic [15:0] frame_length;
		status_t     status;
	} out_item_t;

	typedef struct packed {
		logic [15:0] max_len;
		logic [31:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic      has_result;
		out_item_t item;
	} step_res_t;

	// One byte of CRC-16/MODBUS, reflected, eight shift steps.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// File: rtl/cfpr_stream_if.sv
// Valid/ready stream channel carrying one item per handshake.
interface cfpr_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/cfpr_apb_regs.sv
// APB configuration registers: max_len and timeout_ticks.
module cfpr_apb_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cfpr_pkg::APB_AW-1:0]   paddr,
	input  logic [cfpr_pkg::APB_DW-1:0]   pwdata,
	output logic [cfpr_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	output cfpr_pkg::cfg_t                cfg
);
	import cfpr_pkg::*;

	logic [15:0] max_len_q;
	logic [31:0] timeout_q;
	logic        wr_en;
	reg_idx_t    idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign idx    = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RST;
			timeout_q <= TIMEOUT_RST;
		end else if (wr_en) begin
			case (idx)
				REG_MAX_LEN: max_len_q <= pwdata[15:0];
				REG_TIMEOUT: timeout_q <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MAX_LEN: prdata = {16'h0000, max_len_q};
			REG_TIMEOUT: prdata = timeout_q;
			default:     prdata = '0;
		endcase
	end

	assign cfg.max_len       = max_len_q;
	assign cfg.timeout_ticks = timeout_q;
endmodule

// File: rtl/cfpr_frame_core.sv
// Frame parser state: sync hunt, header, payload, CRC check and attempt timer.
module cfpr_frame_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  cfpr_pkg::in_item_t   item,
	input  cfpr_pkg::cfg_t       cfg,
	output cfpr_pkg::step_res_t  res
);
	import cfpr_pkg::*;

	phase_t      phase_q,  phase_n;
	logic [7:0]  cmd_q,    cmd_n;
	logic [15:0] len_q,    len_n;
	logic [15:0] left_q,   left_n;
	logic [15:0] crc_q,    crc_n;
	logic [7:0]  crclo_q,  crclo_n;
	logic [31:0] timer_q,  timer_n;

	logic        do_fin;
	status_t     fin_st;
	logic [15:0] crc_upd;
	logic [15:0] len_full;
	logic [7:0]  b;

	assign b        = item.rx_byte;
	assign crc_upd  = crc16_byte(crc_q, b);
	assign len_full = {b, len_q[7:0]};

	always_comb begin
		phase_n = phase_q;
		cmd_n   = cmd_q;
		len_n   = len_q;
		left_n  = left_q;
		crc_n   = crc_q;
		crclo_n = crclo_q;
		timer_n = timer_q;
		do_fin  = 1'b0;
		fin_st  = ST_OK;
		res     = '0;

		if (step) begin
			if (item.func) begin
				timer_n = (timer_q == '1) ? timer_q : timer_q + 32'd1;
				if (timer_n >= cfg.timeout_ticks) begin
					do_fin = 1'b1;
					fin_st = ST_TIMEOUT;
				end
			end else begin
				case (phase_q)
					PH_HUNT1: if (b == SYNC_A) phase_n = PH_HUNT2;
					PH_HUNT2: begin
						if (b == SYNC_B)
							phase_n = PH_CMD;
						else if (b != SYNC_A)
							phase_n = PH_HUNT1;
					end
					PH_CMD: begin
						cmd_n   = b;
						crc_n   = crc_upd;
						phase_n = PH_LENLO;
					end
					PH_LENLO: begin
						len_n   = {8'h00, b};
						crc_n   = crc_upd;
						phase_n = PH_LENHI;
					end
					PH_LENHI: begin
						len_n  = len_full;
						crc_n  = crc_upd;
						left_n = len_full;
						if (len_full > cfg.max_len) begin
							do_fin = 1'b1;
							fin_st = ST_LEN_LONG;
						end else begin
							phase_n = (len_full == 16'd0) ? PH_CRCLO : PH_DATA;
						end
					end
					PH_DATA: begin
						crc_n  = crc_upd;
						left_n = left_q - 16'd1;
						if (left_n == 16'd0) phase_n = PH_CRCLO;
						res.has_result        = 1'b1;
						res.item.is_end       = 1'b0;
						res.item.payload_byte = b;
						res.item.command      = cmd_q;
						res.item.frame_length = len_q;
						res.item.status       = ST_OK;
					end
					PH_CRCLO: begin
						crclo_n = b;
						phase_n = PH_CRCHI;
					end
					PH_CRCHI: begin
						do_fin = 1'b1;
						fin_st = ({b, crclo_q} == crc_q) ? ST_OK : ST_CRC_BAD;
					end
					default: phase_n = PH_HUNT1;
				endcase
			end

			if (do_fin) begin
				res.has_result        = 1'b1;
				res.item.is_end       = 1'b1;
				res.item.payload_byte = 8'h00;
				res.item.command      = cmd_n;
				res.item.frame_length = len_n;
				res.item.status       = fin_st;
				// restart the attempt
				phase_n = PH_HUNT1;
				cmd_n   = '0;
				len_n   = '0;
				left_n  = '0;
				crc_n   = CRC_INIT;
				crclo_n = '0;
				timer_n = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT1;
			cmd_q   <= '0;
			len_q   <= '0;
			left_q  <= '0;
			crc_q   <= CRC_INIT;
			crclo_q <= '0;
			timer_q <= '0;
		end else begin
			phase_q <= phase_n;
			cmd_q   <= cmd_n;
			len_q   <= len_n;
			left_q  <= left_n;
			crc_q   <= crc_n;
			crclo_q <= crclo_n;
			timer_q <= timer_n;
		end
	end
endmodule

// File: rtl/crc16_framed_packet_receiver_unit.sv
// Top level of the CRC-16 framed packet receiver.
//
//  channel  | dir | handshake          | carries
//  ---------+-----+--------------------+---------------------------------------------
//  in_ch    | in  | valid/ready        | func, rx_byte
//  out_ch   | out | valid/ready        | is_end, payload_byte, command, frame_length, status
//  apb      | in  | psel/penable/pready| max_len at 0x0, timeout_ticks at 0x4
//
// One item per cycle while out_ch is not stalled: an item waits in the input register,
// then the parser and CRC byte step update the state and load the result register.
// Reset clears the parser state, the timer and both valid flags.
// A result stalled on out_ch holds the input register; one more item is still
// taken only while the input register is empty.
module crc16_framed_packet_receiver_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cfpr_pkg::APB_AW-1:0] paddr,
	input  logic [cfpr_pkg::APB_DW-1:0] pwdata,
	output logic [cfpr_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	cfpr_stream_if.sink                 in_ch,
	cfpr_stream_if.source               out_ch
);
	import cfpr_pkg::*;

	cfg_t      cfg;
	step_res_t res;
	logic      valid_s1;
	in_item_t  item_s1;
	logic      out_valid_q;
	out_item_t out_item_q;
	logic      advance;

	cfpr_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// advance the held item only when the result slot is free or draining
	assign advance     = valid_s1 & (~out_valid_q | out_ch.ready);
	assign in_ch.ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			item_s1.func    <= in_ch.data.func;
			item_s1.rx_byte <= in_ch.data.rx_byte;
		end
	end

	cfpr_frame_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.has_result;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.has_result) begin
			out_item_q <= res.item;
		end
	end

	assign out_ch.valid             = out_valid_q;
	assign out_ch.data.is_end       = out_item_q.is_end;
	assign out_ch.data.payload_byte = out_item_q.payload_byte;
	assign out_ch.data.command      = out_item_q.command;
	assign out_ch.data.frame_length = out_item_q.frame_length;
	assign out_ch.data.status       = out_item_q.status;
endmodule

// File: rtl/cfpr_checker.sv
// Port-level checks on the receiver and their binding to the top level.
`include "assert_macros.svh"

module cfpr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        is_end,
	input logic [7:0]  payload_byte,
	input logic [7:0]  command,
	input logic [15:0] frame_length,
	input logic [1:0]  status
);
	import cfpr_pkg::*;

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped")
	`ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable({is_end, payload_byte, command, frame_length, status}), "stalled result changed")
	`ASSERT_IMPL(a_payload_ok, clk, arst_n, out_valid && !is_end, status == ST_OK, "payload item with status")
	`ASSERT_IMPL(a_end_nobyte, clk, arst_n, out_valid && is_end, payload_byte == 8'h00, "end item with byte")
endmodule

bind crc16_framed_packet_receiver_unit cfpr_checker u_cfpr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.is_end       (out_ch.data.is_end),
	.payload_byte (out_ch.data.payload_byte),
	.command      (out_ch.data.command),
	.frame_length (out_ch.data.frame_length),
	.status       (out_ch.data.status)
);
